/* sv/fct_pkg.sv */
// Shared types and constants of the frustum cull tester.
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

   // Width of the exact distance path: products, sums and doubled box distances.
   localparam int unsigned DIST_W = 68;

   // Width of each word on the request and response channels.
   localparam int unsigned REQ_DATA_W = 224;
   localparam int unsigned REQ_USER_W = 2;
   localparam int unsigned RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_POINT  = 2'd1,
      OP_SPHERE = 2'd2,
      OP_BOX    = 2'd3
   } fct_op_type;

   localparam logic [1:0] CLS_INSIDE    = 2'd0;
   localparam logic [1:0] CLS_INTERSECT = 2'd1;
   localparam logic [1:0] CLS_OUTSIDE   = 2'd2;

   // One stored plane: normal and offset, all Q16.16.
   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [31:0] off;
   } fct_plane_type;

   // Operands of the object under test, held for the whole test.
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic signed [31:0] radius;
      logic [30:0]        sx;
      logic [30:0]        sy;
      logic [30:0]        sz;
   } fct_obj_type;

   // Per-plane control traveling down the evaluation pipeline.
   typedef struct packed {
      logic       valid;
      logic       last;
      fct_op_type op;
   } fct_ctl_type;

   // Per-plane verdict returned to the sequencer.
   typedef struct packed {
      logic valid;
      logic last;
      logic outside;
      logic partial;
   } fct_flag_type;

endpackage

`default_nettype wire

/* sv/fct_plane_mem.sv */
// Plane store: synchronous memory with a registered read and per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module fct_plane_mem #(
   parameter int NUM_PLANES = 6
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      wr_en,
   input  wire logic [((NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1)-1:0] wr_addr,
   input  wire fct_pkg::fct_plane_type    wr_data,
   input  wire logic                      rd_en,
   input  wire logic [((NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1)-1:0] rd_addr,
   output fct_pkg::fct_plane_type         rd_data
);
   import fct_pkg::*;

   fct_plane_type             plane_mem [NUM_PLANES];
   logic [NUM_PLANES-1:0]     vld_ff;
   fct_plane_type             rd_data_ff;
   logic                      rd_vld_ff;

   // Valid bits: an entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         plane_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= plane_mem[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* sv/fct_plane_eval.sv */
// Per-plane distance pipeline: multiply, sum, then sign tests for the object kind.
`timescale 1ns / 1ps
`default_nettype none

module fct_plane_eval (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fct_pkg::fct_ctl_type   ctl,
   input  wire fct_pkg::fct_plane_type plane,
   input  wire fct_pkg::fct_obj_type   obj,
   output fct_pkg::fct_flag_type       flag
);
   import fct_pkg::*;

   logic [31:0]               mag_x;
   logic [31:0]               mag_y;
   logic [31:0]               mag_z;

   logic signed [63:0]        p_x_in, p_y_in, p_z_in;
   logic signed [63:0]        p_x_ff, p_y_ff, p_z_ff;
   logic [62:0]               q_x_in, q_y_in, q_z_in;
   logic [62:0]               q_x_ff, q_y_ff, q_z_ff;
   logic signed [31:0]        off_ff;
   fct_ctl_type               ctl2_ff;

   logic [DIST_W-1:0]         off_ext;
   logic [DIST_W-1:0]         dist_in, dist_ff;
   logic [DIST_W-1:0]         qsum_in, qsum_ff;
   fct_ctl_type               ctl3_ff;

   logic [DIST_W-1:0]         rad_ext;
   logic [DIST_W-1:0]         sph_lo;
   logic [DIST_W-1:0]         sph_hi;
   logic [DIST_W-1:0]         box_pos;
   logic [DIST_W-1:0]         box_neg;

   // Stage 1: products of the normal with the center and of |normal| with the extent.
   assign mag_x = plane.nx[31] ? (~plane.nx + 32'd1) : plane.nx;
   assign mag_y = plane.ny[31] ? (~plane.ny + 32'd1) : plane.ny;
   assign mag_z = plane.nz[31] ? (~plane.nz + 32'd1) : plane.nz;

   assign p_x_in = $signed(plane.nx) * $signed(obj.cx);
   assign p_y_in = $signed(plane.ny) * $signed(obj.cy);
   assign p_z_in = $signed(plane.nz) * $signed(obj.cz);
   assign q_x_in = mag_x * obj.sx;
   assign q_y_in = mag_y * obj.sy;
   assign q_z_in = mag_z * obj.sz;

   always_ff @(posedge clock) begin
      p_x_ff <= p_x_in;
      p_y_ff <= p_y_in;
      p_z_ff <= p_z_in;
      q_x_ff <= q_x_in;
      q_y_ff <= q_y_in;
      q_z_ff <= q_z_in;
      off_ff <= plane.off;
   end

   // Stage 2: center distance in Q32.32 and the box half-spread times two.
   assign off_ext = {{(DIST_W-48){off_ff[31]}}, off_ff, 16'h0000};
   assign dist_in = DIST_W'(p_x_ff) + DIST_W'(p_y_ff) + DIST_W'(p_z_ff) + off_ext;
   assign qsum_in = DIST_W'(q_x_ff) + DIST_W'(q_y_ff) + DIST_W'(q_z_ff);

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      qsum_ff <= qsum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else begin
         ctl2_ff <= ctl;
         ctl3_ff <= ctl2_ff;
      end
   end

   // Stage 3: sign tests.
   assign rad_ext = {{(DIST_W-48){obj.radius[31]}}, obj.radius, 16'h0000};
   assign sph_lo  = dist_ff + rad_ext;
   assign sph_hi  = dist_ff - rad_ext;
   assign box_pos = {dist_ff[DIST_W-2:0], 1'b0} + qsum_ff;
   assign box_neg = {dist_ff[DIST_W-2:0], 1'b0} - qsum_ff;

   always_comb begin
      flag.valid   = ctl3_ff.valid;
      flag.last    = ctl3_ff.last;
      flag.outside = 1'b0;
      flag.partial = 1'b0;
      unique case (ctl3_ff.op)
         OP_POINT: begin
            flag.outside = dist_ff[DIST_W-1];
         end
         OP_SPHERE: begin
            flag.outside = sph_lo[DIST_W-1];
            flag.partial = sph_hi[DIST_W-1];
         end
         OP_BOX: begin
            flag.outside = box_pos[DIST_W-1];
            flag.partial = box_neg[DIST_W-1];
         end
         OP_LOAD: begin
            flag.outside = 1'b0;
         end
         default: begin
            flag.outside = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/frustum_cull_tester_unit.sv */
// Top level of the frustum cull tester: request decode, plane sequencer and response register.
//
// Usage
//   Request channel (req_*): one word per command. tuser carries the opcode:
//   load plane, test point, test sphere or test box. A load writes the normal and
//   offset into the plane store and returns nothing; a load to an index at or above
//   NUM_PLANES is dropped. A test returns exactly one response word.
//   Response channel (rsp_*): tdata[1:0] holds the class: inside, intersecting
//   or outside.
//   Sequencing: a load leaves the block ready for the next request. A test visits
//   one stored plane per cycle and then drains a three-stage distance pipeline
//   (multiply, sum, sign test); the next request is not taken until the class of
//   the test has been handed to the output register. The plane memory read port
//   and the per-plane sweep set the pace of a test.
//   Reset clears the control state and all plane valid bits, so every plane reads
//   as zero until it is loaded. No clearing sweep is needed.
//   A stalled receiver holds the response word in its output register; the block
//   still takes the next request and holds the finished class of that one until
//   the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module frustum_cull_tester_unit #(
   parameter int NUM_PLANES = 6
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata, from bit 0 up: plane_index[3], coord_x[32], coord_y[32], coord_z[32],
   // scalar_value[32], size_x[31], size_y[31], size_z[31]
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [fct_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: opcode[2]
   input  wire logic [fct_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // rsp_tdata, from bit 0 up: cull_class[2], zero fill
   output logic [fct_pkg::RSP_DATA_W-1:0]           rsp_tdata
);
   import fct_pkg::*;

   localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PLANES - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   fct_op_type           op_ff, op_in;
   fct_obj_type          obj_ff, obj_in;
   logic                 acc_out_ff, acc_out_in;
   logic                 acc_part_ff, acc_part_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]           cls_ff, cls_in;
   fct_ctl_type          ctl1_ff, ctl1_in;

   logic                 req_accept;
   fct_op_type           req_op;
   logic [2:0]           req_plane_index;
   fct_obj_type          req_obj;
   fct_plane_type        wr_plane;
   logic                 wr_en;
   logic                 rd_en;
   fct_plane_type        rd_plane;
   fct_flag_type         flag;

   // Unpack the request word.
   assign req_op          = fct_op_type'(req_tuser);
   assign req_plane_index = req_tdata[2:0];
   assign req_obj.cx      = req_tdata[34:3];
   assign req_obj.cy      = req_tdata[66:35];
   assign req_obj.cz      = req_tdata[98:67];
   assign req_obj.radius  = req_tdata[130:99];
   assign req_obj.sx      = req_tdata[161:131];
   assign req_obj.sy      = req_tdata[192:162];
   assign req_obj.sz      = req_tdata[223:193];

   assign wr_plane.nx  = req_obj.cx;
   assign wr_plane.ny  = req_obj.cy;
   assign wr_plane.nz  = req_obj.cz;
   assign wr_plane.off = req_obj.radius;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      op_in         = op_ff;
      obj_in        = obj_ff;
      acc_out_in    = acc_out_ff;
      acc_part_in   = acc_part_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cls_in        = cls_ff;
      ctl1_in       = '0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_op == OP_LOAD) begin
                  // Drop loads aimed past the last plane.
                  wr_en = (int'(req_plane_index) < NUM_PLANES);
               end else begin
                  op_in       = req_op;
                  obj_in      = req_obj;
                  k_in        = '0;
                  acc_out_in  = 1'b0;
                  acc_part_in = 1'b0;
                  state_in    = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            // Read one plane per cycle and tag it for the pipeline.
            rd_en         = 1'b1;
            ctl1_in.valid = 1'b1;
            ctl1_in.last  = (k_ff == LAST_IDX);
            ctl1_in.op    = op_ff;
            if (k_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_DRAIN;
         end
         S_DONE: begin
            // Hand the class over once the output register is free.
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               cls_in        = acc_out_ff  ? CLS_OUTSIDE :
                               acc_part_ff ? CLS_INTERSECT : CLS_INSIDE;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Collect per-plane verdicts; outside wins over intersecting.
      if (flag.valid) begin
         acc_out_in  = acc_out_ff | flag.outside;
         acc_part_in = acc_part_ff | flag.partial;
         if (flag.last) begin
            state_in = S_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         k_ff          <= '0;
         acc_out_ff    <= 1'b0;
         acc_part_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         ctl1_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         k_ff          <= k_in;
         acc_out_ff    <= acc_out_in;
         acc_part_ff   <= acc_part_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         ctl1_ff       <= ctl1_in;
      end
   end

   // Payload registers: held by the item, no reset needed.
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      obj_ff <= obj_in;
      cls_ff <= cls_in;
   end

   fct_plane_mem #(
      .NUM_PLANES (NUM_PLANES)
   ) u_plane_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (req_plane_index[IDX_W-1:0]),
      .wr_data (wr_plane),
      .rd_en   (rd_en),
      .rd_addr (k_ff),
      .rd_data (rd_plane)
   );

   fct_plane_eval u_plane_eval (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl1_ff),
      .plane (rd_plane),
      .obj   (obj_ff),
      .flag  (flag)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2){1'b0}}, cls_ff};

endmodule

`default_nettype wire

/* test/fct_checker.sv */
// Watches the request and response channels, predicts each cull class and compares.
`timescale 1ns / 1ps

module fct_checker #(
   parameter int NUM_PLANES = 6
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   input  wire logic                             req_tready,
   input  wire logic [fct_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [fct_pkg::REQ_USER_W-1:0]   req_tuser,
   input  wire logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic [fct_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output int                                    fail_count,
   output int                                    outstanding,
   output int                                    checked
);
   import fct_pkg::*;

   typedef logic signed [95:0] wide_type;

   logic signed [31:0] plane_nx  [NUM_PLANES];
   logic signed [31:0] plane_ny  [NUM_PLANES];
   logic signed [31:0] plane_nz  [NUM_PLANES];
   logic signed [31:0] plane_off [NUM_PLANES];

   logic [1:0] expected_class_q [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
      checked     = 0;
   end

   // Exact dot(n, p) + offset in Q32.32 for one stored plane.
   function automatic wide_type plane_distance(input int k, input logic signed [31:0] px,
                                               input logic signed [31:0] py,
                                               input logic signed [31:0] pz);
      wide_type nx, ny, nz, off, ex, ey, ez;
      nx  = plane_nx[k];
      ny  = plane_ny[k];
      nz  = plane_nz[k];
      off = plane_off[k];
      ex  = px;
      ey  = py;
      ez  = pz;
      return nx * ex + ny * ey + nz * ez + (off <<< 16);
   endfunction

   function automatic wide_type magnitude(input logic signed [31:0] v);
      wide_type w;
      w = v;
      return (w < 0) ? -w : w;
   endfunction

   // Classify a point, sphere or box against every plane.
   function automatic logic [1:0] classify_object(input fct_op_type op,
                                                  input logic signed [31:0] cx,
                                                  input logic signed [31:0] cy,
                                                  input logic signed [31:0] cz,
                                                  input logic signed [31:0] radius,
                                                  input logic [30:0] sx,
                                                  input logic [30:0] sy,
                                                  input logic [30:0] sz);
      wide_type center_dist, rad, spread, ux, uy, uz;
      bit       any_out, any_part;
      int       k;
      any_out  = 1'b0;
      any_part = 1'b0;
      rad = radius;
      rad = rad <<< 16;
      ux  = sx;
      uy  = sy;
      uz  = sz;
      for (k = 0; k < NUM_PLANES; k++) begin
         center_dist = plane_distance(k, cx, cy, cz);
         case (op)
            OP_POINT: begin
               if (center_dist < 0) any_out = 1'b1;
            end
            OP_SPHERE: begin
               if (center_dist + rad < 0) any_out = 1'b1;
               else if (center_dist - rad < 0) any_part = 1'b1;
            end
            default: begin
               // work on twice the distance so the half extents stay exact
               spread = magnitude(plane_nx[k]) * ux + magnitude(plane_ny[k]) * uy
                        + magnitude(plane_nz[k]) * uz;
               if ((center_dist <<< 1) + spread < 0) any_out = 1'b1;
               else if ((center_dist <<< 1) - spread < 0) any_part = 1'b1;
            end
         endcase
      end
      if (any_out) return CLS_OUTSIDE;
      if (any_part) return CLS_INTERSECT;
      return CLS_INSIDE;
   endfunction

   always @(posedge clock) begin
      logic [2:0]  idx;
      logic [1:0]  want;
      fct_op_type  op;
      if (reset) begin
         for (int k = 0; k < NUM_PLANES; k++) begin
            plane_nx[k]  = '0;
            plane_ny[k]  = '0;
            plane_nz[k]  = '0;
            plane_off[k] = '0;
         end
         expected_class_q.delete();
      end else begin
         // retire the response word first; its request was taken earlier
         if (rsp_tvalid && rsp_tready) begin
            if (expected_class_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: response word with no test pending, class %0d",
                           rsp_tdata[1:0]);
            end else begin
               want = expected_class_q.pop_front();
               checked++;
               if (rsp_tdata[1:0] !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: cull_class expected %0d got %0d", want,
                              rsp_tdata[1:0]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            op  = fct_op_type'(req_tuser);
            idx = req_tdata[2:0];
            if (op == OP_LOAD) begin
               // drop loads past the last plane
               if (idx < NUM_PLANES) begin
                  plane_nx[idx]  = req_tdata[34:3];
                  plane_ny[idx]  = req_tdata[66:35];
                  plane_nz[idx]  = req_tdata[98:67];
                  plane_off[idx] = req_tdata[130:99];
               end
            end else begin
               expected_class_q.push_back(classify_object(op, req_tdata[34:3],
                  req_tdata[66:35], req_tdata[98:67], req_tdata[130:99],
                  req_tdata[161:131], req_tdata[192:162], req_tdata[223:193]));
            end
         end
      end
      outstanding = expected_class_q.size();
   end

endmodule

/* test/frustum_cull_tester_unit_tb.sv */
// Testbench top for the frustum cull tester: stimulus, response pacing and verdict.
`timescale 1ns / 1ps

module frustum_cull_tester_unit_tb;
   import fct_pkg::*;

   localparam int          NUM_PLANES  = 6;
   localparam int          CYCLE_LIMIT = 400000;
   localparam logic [31:0] S32_MIN     = 32'h8000_0000;
   localparam logic [31:0] S32_MAX     = 32'h7fff_ffff;
   localparam logic [30:0] U31_MAX     = 31'h7fff_ffff;
   localparam logic [31:0] ONE         = 32'h0001_0000;   // 1.0 in Q16.16
   localparam logic [31:0] NEG_ONE     = 32'hffff_0000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // plane_index[3], coord_x[32], coord_y[32], coord_z[32], scalar_value[32],
   // size_x[31], size_y[31], size_z[31]
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   // opcode[2]
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // cull_class[2], zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int fail_count, outstanding, checked;
   int cycle_count = 0;
   int op_count [4] = '{0, 0, 0, 0};
   int dropped_loads = 0;
   // high during the stretch where neither side idles
   logic calm = 1'b0;

   always #1 clock = ~clock;

   frustum_cull_tester_unit #(.NUM_PLANES(NUM_PLANES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   fct_checker #(.NUM_PLANES(NUM_PLANES)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .checked     (checked)
   );

   // Stall the response side at random, about 13 percent of the time, never while calm.
   always @(posedge clock)
      rsp_tready <= calm || ($urandom_range(0, 99) >= 13);

   // Watchdog: abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offer one request word and hold it until the block takes it.
   task automatic send_word(input fct_op_type op, input logic [2:0] idx,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic [31:0] scalar,
                            input logic [30:0] sx, input logic [30:0] sy,
                            input logic [30:0] sz);
      // idle the request side now and then
      if (!calm && $urandom_range(0, 99) < 13) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= {sz, sy, sx, scalar, z, y, x, idx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      op_count[op]++;
      if (op == OP_LOAD && idx >= NUM_PLANES) dropped_loads++;
   endtask

   task automatic load_plane(input logic [2:0] idx, input logic [31:0] nx,
                             input logic [31:0] ny, input logic [31:0] nz,
                             input logic [31:0] off);
      send_word(OP_LOAD, idx, nx, ny, nz, off, 31'($urandom), 31'($urandom),
                31'($urandom));
   endtask

   // Mostly coordinates near the frustum, sometimes anything at all.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2:       return $urandom_range(0, 1) ? S32_MIN : S32_MAX;
         default: return $urandom_range(0, 40 * 65536) - 20 * 65536;
      endcase
   endfunction

   function automatic logic [30:0] rand_extent();
      case ($urandom_range(0, 9))
         0:       return 31'($urandom);
         1:       return $urandom_range(0, 1) ? U31_MAX : 31'd0;
         default: return 31'($urandom_range(0, 16 * 65536));
      endcase
   endfunction

   initial begin
      logic [2:0]  idx;
      logic [31:0] nx, ny, nz, off;
      int          roll;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // all planes still zero after reset: every distance is zero
      send_word(OP_POINT, 3'd0, '0, '0, '0, '0, '0, '0, '0);
      send_word(OP_POINT, 3'd7, S32_MIN, S32_MAX, S32_MIN, '0, '0, '0, '0);
      send_word(OP_SPHERE, 3'd0, '0, '0, '0, ONE, '0, '0, '0);
      send_word(OP_SPHERE, 3'd0, '0, '0, '0, '0, '0, '0, '0);
      send_word(OP_SPHERE, 3'd0, '0, '0, '0, S32_MIN, '0, '0, '0);
      send_word(OP_BOX, 3'd0, S32_MAX, S32_MIN, S32_MAX, '0, U31_MAX, U31_MAX, U31_MAX);

      // loads past the last plane must be dropped
      load_plane(3'd6, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
      load_plane(3'd7, S32_MAX, S32_MAX, S32_MAX, S32_MIN);
      send_word(OP_POINT, 3'd0, S32_MAX, S32_MAX, S32_MAX, '0, '0, '0, '0);

      // a cube of half width 10 around the origin
      load_plane(3'd0, ONE, '0, '0, 10 * ONE);
      load_plane(3'd1, NEG_ONE, '0, '0, 10 * ONE);
      load_plane(3'd2, '0, ONE, '0, 10 * ONE);
      load_plane(3'd3, '0, NEG_ONE, '0, 10 * ONE);
      load_plane(3'd4, '0, '0, ONE, 10 * ONE);
      load_plane(3'd5, '0, '0, NEG_ONE, 10 * ONE);
      send_word(OP_POINT, 3'd0, '0, '0, '0, '0, '0, '0, '0);
      send_word(OP_POINT, 3'd0, 11 * ONE, '0, '0, '0, '0, '0, '0);
      send_word(OP_SPHERE, 3'd0, 9 * ONE, '0, '0, 2 * ONE, '0, '0, '0);
      send_word(OP_SPHERE, 3'd0, '0, '0, '0, NEG_ONE, '0, '0, '0);
      send_word(OP_BOX, 3'd0, '0, '0, '0, '0, 4 * ONE, 4 * ONE, 4 * ONE);
      send_word(OP_BOX, 3'd0, '0, '0, '0, '0, 22 * ONE, 4 * ONE, 4 * ONE);
      send_word(OP_BOX, 3'd0, 30 * ONE, '0, '0, '0, 4 * ONE, 4 * ONE, 4 * ONE);

      // a plane at the limits of every field
      load_plane(3'd5, S32_MIN, S32_MAX, S32_MIN, S32_MIN);
      send_word(OP_SPHERE, 3'd0, S32_MIN, S32_MIN, S32_MAX, S32_MAX, '0, '0, '0);
      send_word(OP_BOX, 3'd0, S32_MIN, S32_MAX, S32_MIN, '0, U31_MAX, U31_MAX, U31_MAX);

      // --- random part ---
      for (int n = 0; n < 1250; n++) begin
         calm <= (n >= 500 && n < 700);
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            idx = (roll < 2) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
            if ($urandom_range(0, 4) != 0) begin
               // well-formed plane: modest normal, offset within +-16
               nx  = $urandom_range(0, 2 * 65536) - 65536;
               ny  = $urandom_range(0, 2 * 65536) - 65536;
               nz  = $urandom_range(0, 2 * 65536) - 65536;
               off = $urandom_range(0, 32 * 65536) - 16 * 65536;
            end else begin
               nx  = $urandom;
               ny  = $urandom;
               nz  = $urandom;
               off = $urandom;
            end
            load_plane(idx, nx, ny, nz, off);
         end else begin
            send_word(fct_op_type'($urandom_range(1, 3)), 3'($urandom),
                      rand_coord(), rand_coord(), rand_coord(),
                      ($urandom_range(0, 4) == 0) ? 32'($urandom)
                                                  : 32'($urandom_range(0, 12 * 65536)),
                      rand_extent(), rand_extent(), rand_extent());
         end
      end
      req_tvalid <= 1'b0;
      calm       <= 1'b0;

      // drain: wait for every pending class, then a little longer for strays
      while (outstanding != 0) @(posedge clock);
      repeat (24) @(posedge clock);

      $display("covered %0d plane loads (%0d dropped), %0d point, %0d sphere, %0d box tests",
               op_count[OP_LOAD], dropped_loads, op_count[OP_POINT], op_count[OP_SPHERE],
               op_count[OP_BOX]);
      $display("checked %0d classes, %0d mismatches", checked, fail_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
